[hw/rtl/dq_pkg.sv]
// Shared constants, opcode and status codes for the indexed deque.
package dq_pkg;

  // Store geometry
  localparam int CAPACITY   = 256;
  localparam int ITEM_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Fixed field widths at the ports
  localparam int OP_W       = 3;
  localparam int VALUE_W    = 32;
  localparam int POS_W      = 8;
  localparam int OUT_CNT_W  = 9;
  localparam int STATUS_W   = 2;

  // Operation codes; 5 to 7 are no-ops
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

endpackage

[hw/rtl/dq_ram.sv]
// Simple dual-port RAM: one write port, one registered read port.
module dq_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/double_ended_queue_indexed_top.sv]
// Indexed double-ended queue on a circular RAM store.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------
//  req     | in        | req_valid / req_ready | opcode, item_value, position
//  rsp     | out       | rsp_valid / rsp_ready | read_value, entry_count, is_empty, status
//
// One transaction per cycle: pointer and count update at acceptance, the RAM
// read issued in the same cycle returns on the next, when the result shows.
// The result register frees req_ready whenever it is empty or being taken.
// A stalled response holds the RAM read data and blocks new requests.
// Synchronous reset empties the queue; RAM contents are left as they are.
module double_ended_queue_indexed_top
  import dq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic [OP_W-1:0]      opcode,
  input  logic [VALUE_W-1:0]   item_value,
  input  logic [POS_W-1:0]     position,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output logic [VALUE_W-1:0]   read_value,
  output logic [OUT_CNT_W-1:0] entry_count,
  output logic                 is_empty,
  output logic [STATUS_W-1:0]  status
);

  localparam int SUM_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Queue state
  logic [ADDR_W-1:0] front_ptr, front_ptr_next;
  logic [CNT_W-1:0]  count, count_next;

  // Result register
  logic              res_read_ok;
  logic [CNT_W-1:0]  res_count;
  status_t           res_status;

  // Decode signals
  logic              req_fire;
  logic              rsp_fire;
  status_t           status_next;
  logic              read_ok_next;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ITEM_WIDTH-1:0] mem_rdata;
  logic              is_full;
  logic              no_items;

  // Reduce a sum below twice the capacity into a slot index
  function automatic logic [ADDR_W-1:0] wrap_slot(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] cap;
    cap = SUM_W'(CAPACITY);
    if (s >= cap) begin
      wrap_slot = ADDR_W'(s - cap);
    end else begin
      wrap_slot = ADDR_W'(s);
    end
  endfunction

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;
  assign req_ready = !rsp_valid || rsp_ready;

  assign is_full  = (count >= CNT_W'(CAPACITY));
  assign no_items = (count == '0);

  // Read slot is front plus position, back slot is front plus count
  assign mem_raddr = wrap_slot(SUM_W'(front_ptr) + SUM_W'(position));

  // Operation decode
  always_comb begin
    front_ptr_next = front_ptr;
    count_next     = count;
    status_next    = ST_OK;
    read_ok_next   = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = wrap_slot(SUM_W'(front_ptr) + SUM_W'(count));
    unique case (op_t'(opcode))
      OP_PUSH_FRONT: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          front_ptr_next = (front_ptr == '0) ? ADDR_W'(CAPACITY - 1)
                                             : front_ptr - ADDR_W'(1);
          mem_waddr      = front_ptr_next;
          mem_we         = 1'b1;
          count_next     = count + CNT_W'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          mem_we     = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (no_items) begin
          status_next = ST_EMPTY;
        end else begin
          front_ptr_next = wrap_slot(SUM_W'(front_ptr) + SUM_W'(1));
          count_next     = count - CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (no_items) begin
          status_next = ST_EMPTY;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (no_items) begin
          status_next = ST_EMPTY;
        end else if (SUM_W'(position) >= SUM_W'(count)) begin
          status_next = ST_RANGE;
        end else begin
          read_ok_next = 1'b1;
        end
      end
      default: begin
        // unused opcodes do nothing
      end
    endcase
  end

  // Item store
  dq_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(ITEM_WIDTH)
  ) u_ram (
    .clk  (clk),
    .we   (req_fire && mem_we),
    .waddr(mem_waddr),
    .wdata(ITEM_WIDTH'(item_value)),
    .re   (req_fire),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Queue state and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      front_ptr <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_fire) begin
        front_ptr <= front_ptr_next;
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_fire) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (req_fire) begin
      res_read_ok <= read_ok_next;
      res_count   <= count_next;
      res_status  <= status_next;
    end
  end

  assign read_value  = res_read_ok ? VALUE_W'(mem_rdata) : '0;
  assign entry_count = OUT_CNT_W'(res_count);
  assign is_empty    = (res_count == '0);
  assign status      = res_status;

`ifndef ASSERT_OFF
  // Count never goes past the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("deque count exceeds capacity");

  // A full status is only reported when the queue is at capacity
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (res_status == ST_FULL) |-> res_count == CNT_W'(CAPACITY))
    else $error("full status with room left");

  // A successful front pop lowers the count by one
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    req_fire && (opcode == OP_POP_FRONT) && !no_items |=>
      count == $past(count) - CNT_W'(1))
    else $error("pop front did not decrement count");

  // A stalled response keeps its read data
  a_rdata_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(mem_rdata))
    else $error("read data changed under stall");
`endif

endmodule
